### design/lprp_pkg.sv
package lprp_pkg;

	typedef enum logic [1:0] {
		PH_FRAME_LEN = 2'd0,
		PH_ARG_COUNT = 2'd1,
		PH_ARG_LEN   = 2'd2,
		PH_PAYLOAD   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		V_NONE      = 3'd0,
		V_GET       = 3'd1,
		V_SET       = 3'd2,
		V_DEL       = 3'd3,
		V_UNKNOWN   = 3'd4,
		V_MALFORMED = 3'd5,
		V_TOO_LONG  = 3'd6
	} verdict_t;

	typedef struct packed {
		logic       arg_valid;
		logic [7:0] arg_byte;
		logic [3:0] arg_index;
		logic       arg_last;
		logic       frame_end;
		verdict_t   verdict;
	} result_t;

	localparam logic [3:0]  CFG_MAX_MESSAGE_LEN = 4'd0;
	localparam logic [3:0]  CFG_MAX_ARGUMENTS   = 4'd1;
	localparam logic [15:0] MAX_MESSAGE_LEN_RST = 16'd4096;
	localparam logic [3:0]  MAX_ARGUMENTS_RST   = 4'd10;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_A  = 8'h41;
	localparam logic [7:0] CHAR_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] NAME_LEN = 2'd3;

	// candidate k: 0 get, 1 set, 2 del
	function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (pos)
			2'd0: begin
				case (k)
					2'd0: c = "g";
					2'd1: c = "s";
					2'd2: c = "d";
					default: c = 8'h00;
				endcase
			end
			2'd1: c = "e";
			2'd2: c = (k == 2'd2) ? "l" : "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/lprp_parser.sv
module lprp_parser import lprp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_message_len,
	input  logic [3:0]  max_arguments,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [23:0] acc_q, acc_d;
	logic [15:0] fbl_q, fbl_d;
	logic [3:0]  args_q, args_d;
	logic [3:0]  total_q, total_d;
	logic [3:0]  cur_q, cur_d;
	logic [15:0] abl_q, abl_d;
	logic [1:0]  pos_q, pos_d;
	logic [2:0]  match_q, match_d;
	logic        halt_q, halt_d;

	logic [31:0] hdr_full;
	logic        hdr_done;
	logic [15:0] fbl_dec;
	logic [15:0] abl_dec;
	logic [7:0]  lc;
	logic [1:0]  pos_nx;
	logic [2:0]  match_nx;
	logic        do_next;
	logic [3:0]  ni_args;
	verdict_t    v;
	logic        pay;

	always_comb begin
		hdr_full = {data_byte, acc_q};
		hdr_done = (cnt_q == 2'd3);
		fbl_dec  = (fbl_q != 16'd0) ? fbl_q - 16'd1 : fbl_q;
		abl_dec  = (abl_q != 16'd0) ? abl_q - 16'd1 : abl_q;
		lc = (data_byte >= CHAR_A && data_byte <= CHAR_Z) ? data_byte + CASE_OFFSET : data_byte;

		pos_nx   = pos_q;
		match_nx = match_q;
		if (pos_q < NAME_LEN) begin
			for (int k = 0; k < 3; k++) begin
				if (lc != cand_char(2'(k), pos_q)) match_nx[k] = 1'b0;
			end
			pos_nx = pos_q + 2'd1;
		end else if (data_byte != CHAR_CR && data_byte != CHAR_LF) begin
			match_nx = 3'b000;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		fbl_d   = fbl_q;
		args_d  = args_q;
		total_d = total_q;
		cur_d   = cur_q;
		abl_d   = abl_q;
		pos_d   = pos_q;
		match_d = match_q;
		halt_d  = halt_q;
		v       = V_NONE;
		pay     = 1'b0;
		do_next = 1'b0;
		ni_args = 4'd0;
		res     = '0;

		// header byte collection, shared by the three header phases
		if (phase_q != PH_PAYLOAD) begin
			cnt_d = cnt_q + 2'd1;
			case (cnt_q)
				2'd0: acc_d[7:0]   = data_byte;
				2'd1: acc_d[15:8]  = data_byte;
				2'd2: acc_d[23:16] = data_byte;
				default: acc_d = '0;
			endcase
		end

		case (phase_q)
			PH_FRAME_LEN: begin
				if (hdr_done) begin
					if (hdr_full[31:16] != 16'd0 || hdr_full[15:0] > max_message_len) begin
						v = V_TOO_LONG;
					end else if (hdr_full[31:2] == 30'd0) begin
						v = V_MALFORMED;
					end else begin
						fbl_d   = hdr_full[15:0];
						phase_d = PH_ARG_COUNT;
					end
				end
			end
			PH_ARG_COUNT: begin
				fbl_d = fbl_dec;
				if (hdr_done) begin
					if (hdr_full[31:4] != 28'd0 || hdr_full[3:0] > max_arguments) begin
						v = V_MALFORMED;
					end else begin
						args_d  = hdr_full[3:0];
						total_d = hdr_full[3:0];
						cur_d   = 4'd0;
						do_next = 1'b1;
						ni_args = hdr_full[3:0];
					end
				end
			end
			PH_ARG_LEN: begin
				fbl_d = fbl_dec;
				if (hdr_done) begin
					if (hdr_full[31:16] != 16'd0 || hdr_full[15:0] > fbl_dec) begin
						v = V_MALFORMED;
					end else if (hdr_full[15:0] == 16'd0) begin
						cur_d   = cur_q + 4'd1;
						args_d  = args_q - 4'd1;
						do_next = 1'b1;
						ni_args = args_q - 4'd1;
					end else begin
						abl_d   = hdr_full[15:0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				pay           = 1'b1;
				res.arg_valid = 1'b1;
				res.arg_byte  = data_byte;
				res.arg_index = cur_q;
				res.arg_last  = (abl_q == 16'd1);
				if (cur_q == 4'd0) begin
					pos_d   = pos_nx;
					match_d = match_nx;
				end
				abl_d = abl_dec;
				fbl_d = fbl_dec;
				if (abl_dec == 16'd0) begin
					cur_d   = cur_q + 4'd1;
					args_d  = args_q - 4'd1;
					do_next = 1'b1;
					ni_args = args_q - 4'd1;
				end
			end
			default: ;
		endcase

		// advance to the next argument, or close the frame
		if (do_next) begin
			if (ni_args == 4'd0) begin
				if (fbl_d == 16'd0) begin
					if (pos_d == NAME_LEN && total_d == 4'd2 && match_d[0]) v = V_GET;
					else if (pos_d == NAME_LEN && total_d == 4'd3 && match_d[1]) v = V_SET;
					else if (pos_d == NAME_LEN && total_d == 4'd2 && match_d[2]) v = V_DEL;
					else v = V_UNKNOWN;
					phase_d = PH_FRAME_LEN;
					cnt_d   = 2'd0;
					acc_d   = '0;
					fbl_d   = 16'd0;
					args_d  = 4'd0;
					total_d = 4'd0;
					cur_d   = 4'd0;
					abl_d   = 16'd0;
					pos_d   = 2'd0;
					match_d = 3'b111;
				end else begin
					v = V_MALFORMED;
				end
			end else if (fbl_d < 16'd4) begin
				v = V_MALFORMED;
			end else begin
				phase_d = PH_ARG_LEN;
				cnt_d   = 2'd0;
				acc_d   = '0;
			end
		end

		if (v == V_MALFORMED || v == V_TOO_LONG) halt_d = 1'b1;
		res.frame_end = (v != V_NONE);
		res.verdict   = v;
		res_valid     = !halt_q && (pay || v != V_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FRAME_LEN;
			cnt_q   <= 2'd0;
			acc_q   <= '0;
			fbl_q   <= 16'd0;
			args_q  <= 4'd0;
			total_q <= 4'd0;
			cur_q   <= 4'd0;
			abl_q   <= 16'd0;
			pos_q   <= 2'd0;
			match_q <= 3'b111;
			halt_q  <= 1'b0;
		end else if (step && !halt_q) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			fbl_q   <= fbl_d;
			args_q  <= args_d;
			total_q <= total_d;
			cur_q   <= cur_d;
			abl_q   <= abl_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			halt_q  <= halt_d;
		end
	end

endmodule

### design/length_prefixed_request_parser_top.sv
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  data_byte
// out      source     out_valid/ out_stall arg_valid arg_byte arg_index arg_last
//                                          frame_end verdict
// cfg      sink       cfg_valid/ cfg_ready cfg_index cfg_data
//
// One byte per cycle unless stalled; a byte's result is registered in the next cycle.
// The parser state updates in the accepting cycle, set by the header/payload counters.
// in_stall rises only while the output register is full and out_stall is high.
// arst_n clears all but out_q; limits return to 4096 and 10. cfg_ready is always high.
// After an error every byte is taken and dropped until reset.
module length_prefixed_request_parser_top import lprp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        arg_valid,
	output logic [7:0]  arg_byte,
	output logic [3:0]  arg_index,
	output logic        arg_last,
	output logic        frame_end,
	output logic [2:0]  verdict,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] max_message_len_q;
	logic [3:0]  max_arguments_q;
	logic        step;
	logic        res_valid;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign step      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_message_len_q <= MAX_MESSAGE_LEN_RST;
			max_arguments_q   <= MAX_ARGUMENTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_MESSAGE_LEN: max_message_len_q <= cfg_data;
				CFG_MAX_ARGUMENTS:   max_arguments_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lprp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (data_byte),
		.max_message_len (max_message_len_q),
		.max_arguments   (max_arguments_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign arg_valid = out_q.arg_valid;
	assign arg_byte  = out_q.arg_byte;
	assign arg_index = out_q.arg_index;
	assign arg_last  = out_q.arg_last;
	assign frame_end = out_q.frame_end;
	assign verdict   = out_q.verdict;

endmodule

### sim/parser_monitor.sv
module parser_monitor import lprp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        arg_valid,
	input  logic [7:0]  arg_byte,
	input  logic [3:0]  arg_index,
	input  logic        arg_last,
	input  logic        frame_end,
	input  logic [2:0]  verdict,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	localparam logic [2:0][23:0] CMD_WORDS = {"del", "set", "get"};
	localparam logic [7:0] ASCII_CR = 8'h0d;
	localparam logic [7:0] ASCII_LF = 8'h0a;

	logic [15:0] lim_len;
	logic [3:0]  lim_args;

	phase_t      stage;
	logic [1:0]  hdr_cnt;
	logic [31:0] hdr_word;
	logic [15:0] frame_left;
	logic [3:0]  args_due;
	logic [3:0]  arg_count;
	logic [3:0]  arg_no;
	logic [15:0] arg_left;
	logic [1:0]  name_pos;
	logic [2:0]  name_ok;
	bit          stopped;

	result_t parsed_q[$];

	function automatic void open_frame();
		stage = PH_FRAME_LEN;
		hdr_cnt = '0;
		hdr_word = '0;
		frame_left = '0;
		args_due = '0;
		arg_count = '0;
		arg_no = '0;
		arg_left = '0;
		name_pos = '0;
		name_ok = 3'b111;
	endfunction

	function automatic verdict_t close_frame();
		verdict_t v;
		bit full;
		full = (name_pos == 2'd3);
		v = V_UNKNOWN;
		if (full && arg_count == 4'd2 && name_ok[0])
			v = V_GET;
		else if (full && arg_count == 4'd3 && name_ok[1])
			v = V_SET;
		else if (full && arg_count == 4'd2 && name_ok[2])
			v = V_DEL;
		open_frame();
		return v;
	endfunction

	// move on to the next argument header, or close the frame when none is due
	function automatic verdict_t advance_item();
		if (args_due == 0) begin
			if (frame_left == 0)
				return close_frame();
			return V_MALFORMED;
		end
		if (frame_left < 16'd4)
			return V_MALFORMED;
		stage = PH_ARG_LEN;
		hdr_cnt = '0;
		hdr_word = '0;
		return V_NONE;
	endfunction

	function automatic verdict_t end_arg();
		arg_no = arg_no + 4'd1;
		args_due = args_due - 4'd1;
		return advance_item();
	endfunction

	function automatic void track_name(input logic [7:0] b);
		logic [7:0] lc;
		if (name_pos < 2'd3) begin
			lc = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
			for (int k = 0; k < 3; k++)
				if (lc != CMD_WORDS[k][23 - 8 * name_pos -: 8])
					name_ok[k] = 1'b0;
			name_pos = name_pos + 2'd1;
		end else if (b != ASCII_CR && b != ASCII_LF) begin
			name_ok = '0;
		end
	endfunction

	function automatic bit take_hdr(input logic [7:0] b);
		hdr_word[8 * hdr_cnt +: 8] = b;
		hdr_cnt = hdr_cnt + 2'd1;
		return hdr_cnt == 2'd0;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		verdict_t v;
		bit pay;
		v = V_NONE;
		pay = 1'b0;
		r = '0;
		if (stopped)
			return 1'b0;
		case (stage)
			PH_ARG_COUNT: begin
				if (frame_left != 0) frame_left--;
				if (take_hdr(b)) begin
					if (hdr_word > {28'd0, lim_args}) begin
						v = V_MALFORMED;
					end else begin
						args_due = hdr_word[3:0];
						arg_count = args_due;
						arg_no = '0;
						v = advance_item();
					end
				end
			end
			PH_ARG_LEN: begin
				if (frame_left != 0) frame_left--;
				if (take_hdr(b)) begin
					if (hdr_word > {16'd0, frame_left}) begin
						v = V_MALFORMED;
					end else begin
						arg_left = hdr_word[15:0];
						if (arg_left == 0)
							v = end_arg();
						else
							stage = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				pay = 1'b1;
				r.arg_valid = 1'b1;
				r.arg_byte = b;
				r.arg_index = arg_no;
				r.arg_last = (arg_left == 16'd1);
				if (arg_no == 0) track_name(b);
				if (arg_left != 0) arg_left--;
				if (frame_left != 0) frame_left--;
				if (arg_left == 0) v = end_arg();
			end
			default: begin
				if (take_hdr(b)) begin
					// size limit is checked ahead of the short-frame check
					if (hdr_word > {16'd0, lim_len}) begin
						v = V_TOO_LONG;
					end else if (hdr_word < 32'd4) begin
						v = V_MALFORMED;
					end else begin
						frame_left = hdr_word[15:0];
						stage = PH_ARG_COUNT;
						hdr_word = '0;
						hdr_cnt = '0;
					end
				end
			end
		endcase
		if (v != V_NONE) begin
			r.frame_end = 1'b1;
			r.verdict = v;
			if (v >= V_MALFORMED) stopped = 1'b1;
			return 1'b1;
		end
		return pay;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			lim_len = MAX_MESSAGE_LEN_RST;
			lim_args = MAX_ARGUMENTS_RST;
			stopped = 1'b0;
			open_frame();
			parsed_q.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (parsed_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, actual %s%0h %0h %0h %0h %0h %0h",
						$time, "valid/byte/idx/last/end/verdict ",
						arg_valid, arg_byte, arg_index, arg_last, frame_end, verdict);
				end else begin
					want = parsed_q.pop_front();
					check_field("arg_valid", want.arg_valid, arg_valid);
					check_field("arg_byte", want.arg_byte, arg_byte);
					check_field("arg_index", want.arg_index, arg_index);
					check_field("arg_last", want.arg_last, arg_last);
					check_field("frame_end", want.frame_end, frame_end);
					check_field("verdict", want.verdict, verdict);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_MESSAGE_LEN)
					lim_len = cfg_data;
				else if (cfg_index == CFG_MAX_ARGUMENTS)
					lim_args = cfg_data[3:0];
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, want))
					parsed_q.insert(parsed_q.size(), want);
			end
		end
		outstanding = parsed_q.size();
	end

endmodule

### sim/tb_top.sv
module tb_top;
	import lprp_pkg::*;

	typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
	typedef enum {REQ_GET, REQ_SET, REQ_DEL, REQ_NOISE, REQ_LONG_NAME, REQ_SHORT_NAME} req_kind_t;
	typedef enum {
		F_ZERO_LIMIT, F_WIDE_LEN, F_SHORT, F_MANY_ARGS, F_TRUNCATED, F_OVERLONG, F_SURPLUS
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        arg_valid;
	logic [7:0]  arg_byte;
	logic [3:0]  arg_index;
	logic        arg_last;
	logic        frame_end;
	logic [2:0]  verdict;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;
	int          mismatches;
	int          outstanding;

	length_prefixed_request_parser_top DUT (.*);
	parser_monitor mon (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stall pattern, switches at random among its four modes
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int stall_tick = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: out_stall <= (stall_tick % 8) < 3;
			default:        out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	int          burst_left = 0;
	int          byte_count = 0;
	logic [7:0]  body[$];
	logic [7:0]  arg_buf[$];
	int          n_args;
	logic [3:0]  cur_args = MAX_ARGUMENTS_RST;

	// called at a falling edge, returns at a falling edge after the beat
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		byte_count++;
		@(negedge clk);
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			send_byte(w[8 * i +: 8]);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == CFG_MAX_ARGUMENTS)
			cur_args = val[3:0];
	endtask

	// sender holds off until every result is out
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic add_body(input logic [7:0] b);
		body.insert(body.size(), b);
	endtask

	task automatic add_arg(input logic [7:0] b);
		arg_buf.insert(arg_buf.size(), b);
	endtask

	task automatic start_req();
		body.delete();
		arg_buf.delete();
		n_args = 0;
		repeat (4) add_body(8'h00);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_arg(s[i]);
	endtask

	// command word in random letter case
	task automatic put_cmd(input string s);
		for (int i = 0; i < s.len(); i++)
			add_arg($urandom_range(0, 1) ? s[i] - 8'h20 : s[i]);
	endtask

	task automatic put_random(input int len);
		repeat (len) add_arg(8'($urandom_range(0, 255)));
	endtask

	task automatic put_crlf(input int k);
		repeat (k) add_arg($urandom_range(0, 1) ? 8'h0d : 8'h0a);
	endtask

	task automatic commit_arg();
		logic [31:0] len;
		len = arg_buf.size();
		for (int i = 0; i < 4; i++)
			add_body(len[8 * i +: 8]);
		body = {body, arg_buf};
		arg_buf.delete();
		n_args++;
	endtask

	task automatic send_req(input logic [31:0] len_word, input logic [31:0] count_word);
		for (int i = 0; i < 4; i++)
			body[i] = count_word[8 * i +: 8];
		send_word(len_word);
		foreach (body[i])
			send_byte(body[i]);
	endtask

	task automatic send_wellformed();
		send_req(body.size(), n_args);
	endtask

	task automatic random_req();
		req_kind_t kind;
		int n;
		int want_n;
		start_req();
		kind = req_kind_t'($urandom_range(0, 5));
		want_n = (kind == REQ_SET) ? 3 : 2;
		n = $urandom_range(0, cur_args);
		if (kind <= REQ_DEL && want_n <= cur_args && $urandom_range(0, 3) != 0)
			n = want_n;
		if (n > 0) begin
			case (kind)
				REQ_GET:       put_cmd("get");
				REQ_SET:       put_cmd("set");
				REQ_DEL:       put_cmd("del");
				REQ_NOISE:     put_random($urandom_range(0, 5));
				REQ_LONG_NAME: begin
					put_cmd("get");
					put_random(1);
				end
				default: begin
					put_cmd("del");
					arg_buf.delete(arg_buf.size() - 1);
				end
			endcase
			if (kind <= REQ_DEL && $urandom_range(0, 2) == 0)
				put_crlf($urandom_range(1, 3));
			commit_arg();
			repeat (n - 1) begin
				put_random(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(0, 8));
				commit_arg();
			end
		end
		send_wellformed();
	endtask

	task automatic error_req();
		fault_t fault;
		int k;
		fault = fault_t'($urandom_range(0, 6));
		case (fault)
			F_ZERO_LIMIT: begin
				// size limit wins over the short-frame check
				write_reg(CFG_MAX_MESSAGE_LEN, 16'd0);
				send_word($urandom_range(1, 8));
			end
			F_WIDE_LEN: send_word($urandom | 32'h0001_0000);
			F_SHORT: send_word($urandom_range(0, 3));
			F_MANY_ARGS: begin
				write_reg(CFG_MAX_ARGUMENTS, 16'($urandom_range(0, 15)));
				start_req();
				put_str("get");
				commit_arg();
				// count above the limit, or high count bits set with a low nibble in range
				send_req(body.size(), $urandom_range(0, 1) ? {28'd0, cur_args} + 32'd1
					: 32'h100 << $urandom_range(0, 16));
			end
			F_TRUNCATED: begin
				start_req();
				put_random($urandom_range(0, 5));
				commit_arg();
				send_req(body.size() + $urandom_range(0, 3), 2);
			end
			F_OVERLONG: begin
				k = $urandom_range(1, 6);
				start_req();
				put_random(k);
				commit_arg();
				send_req(body.size() - $urandom_range(1, k), 1);
			end
			default: begin
				start_req();
				put_str("del");
				commit_arg();
				put_random($urandom_range(0, 4));
				commit_arg();
				send_req(body.size() + $urandom_range(1, 3), 2);
			end
		endcase
	endtask

	initial begin
		int start_count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limits; empty request closes on its count header
		start_req();
		send_wellformed();
		start_req(); put_str("GET"); commit_arg(); put_str("k"); commit_arg();
		send_wellformed();
		start_req(); put_cmd("set"); add_arg(8'h0d); add_arg(8'h0a);
		commit_arg(); put_str("key"); commit_arg(); put_random(4); commit_arg();
		send_wellformed();
		start_req(); put_str("dEl"); commit_arg(); put_random(2); commit_arg();
		send_wellformed();
		// right name, wrong count
		start_req(); put_str("get"); commit_arg();
		repeat (2) begin put_random(1); commit_arg(); end
		send_wellformed();
		start_req(); put_str("ge"); commit_arg(); put_random(1); commit_arg();
		send_wellformed();
		start_req(); commit_arg(); put_random(3); commit_arg();
		send_wellformed();
		start_req(); put_str("gets"); commit_arg(); put_random(1); commit_arg();
		send_wellformed();
		// empty last argument closes the frame on a header byte
		start_req(); put_str("set"); commit_arg(); put_str("k"); commit_arg(); commit_arg();
		send_wellformed();
		start_req(); put_str("del"); commit_arg();
		add_arg(8'h00); add_arg(8'hff); commit_arg();
		send_wellformed();

		// both limits at their low end, frame exactly at them
		settle();
		write_reg(CFG_MAX_MESSAGE_LEN, 16'd4);
		write_reg(CFG_MAX_ARGUMENTS, 16'd0);
		start_req();
		send_wellformed();

		// fifteen arguments, frame length exactly at the limit
		settle();
		start_req(); put_str("set"); commit_arg();
		repeat (14) begin put_random($urandom_range(0, 3)); commit_arg(); end
		write_reg(CFG_MAX_MESSAGE_LEN, 16'(body.size()));
		write_reg(CFG_MAX_ARGUMENTS, 16'd15);
		send_wellformed();

		settle();
		write_reg(CFG_MAX_MESSAGE_LEN, 16'hffff);
		start_req(); put_str("set"); commit_arg(); put_str("big"); commit_arg();
		put_random(260); commit_arg();
		send_wellformed();

		start_count = byte_count;
		while (byte_count - start_count < 200) begin
			if ($urandom_range(0, 9) == 0) begin
				settle();
				write_reg(CFG_MAX_ARGUMENTS, 16'($urandom_range(0, 15)));
				if ($urandom_range(0, 1))
					write_reg(CFG_MAX_MESSAGE_LEN, $urandom_range(0, 1) ? 16'hffff
						: 16'($urandom_range(1024, 65535)));
			end
			random_req();
		end

		// one broken frame, then bytes that a stopped parser drops
		settle();
		write_reg(CFG_MAX_MESSAGE_LEN, 16'hffff);
		write_reg(CFG_MAX_ARGUMENTS, 16'd15);
		error_req();
		repeat ($urandom_range(10, 30)) send_byte(8'($urandom_range(0, 255)));

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
